// ----- sv/ctc_pkg.sv -----
// shared types and constants for the console text cleaner
`default_nettype none
package ctc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned MAX_RES = 3;
    localparam int unsigned Q_DEPTH = 2;

    localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CARET  = 8'd94;
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'd0;
    localparam logic [BYTE_W-1:0] ESC_LOW   = 8'd48;
    localparam logic [BYTE_W-1:0] ESC_HIGH  = 8'd64;
    localparam logic [LEN_W:0]    ROOM_MARGIN = 17'd3;
    localparam logic [LEN_W-1:0]  TARGET_RESET = 16'd32768;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_LF    = 2'd1,
        PEND_CARET = 2'd2
    } t_pend;

    // one decoded request: up to three bytes to send, last byte may be the terminator
    typedef struct packed {
        logic [1:0]                     cnt;
        logic [MAX_RES-1:0][BYTE_W-1:0] bytes;
        logic                           last;
        logic [LEN_W-1:0]               length;
    } t_op;

endpackage
`default_nettype wire

// ----- sv/ctc_if.sv -----
// stream interfaces for source text and cleaned results
`default_nettype none
interface ctc_in_if import ctc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface ctc_out_if import ctc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_last;
    logic [LEN_W-1:0]  out_length;

    modport source (output valid, output out_byte, output is_last, output out_length,
                    input ready);
    modport sink   (input valid, input out_byte, input is_last, input out_length,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/ctc_front.sv -----
// front end: accepts source bytes, tracks lookahead and room, builds byte groups
`default_nettype none
module ctc_front import ctc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic              i_eot,
    input  wire logic [LEN_W-1:0]  i_target,
    input  wire logic              i_q_ready,
    output logic                   o_q_valid,
    output t_op                    o_q_op
);

    t_pend            r_pend,  n_pend;
    logic [LEN_W-1:0] r_count, n_count;

    logic [3:0][BYTE_W-1:0] v_b;
    logic [1:0]             v_n;
    logic                   v_step;
    logic                   v_room;
    logic                   accept;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        v_b     = '0;
        v_n     = 2'd0;
        v_step  = 1'b1;
        v_room  = 1'b0;
        n_pend  = PEND_NONE;
        // flush what the lookahead held; a caret followed by an escape byte is dropped with it
        case (r_pend)
            PEND_LF: begin
                v_b[0] = CH_CR;
                v_b[1] = CH_LF;
                v_n    = 2'd2;
                if (!i_eot && i_byte == CH_CR) begin
                    v_step = 1'b0;
                end
            end
            PEND_CARET: begin
                if (!i_eot && i_byte >= ESC_LOW && i_byte <= ESC_HIGH) begin
                    v_step = 1'b0;
                end else begin
                    v_b[0] = CH_CARET;
                    v_n    = 2'd1;
                end
            end
            default: begin
            end
        endcase
        o_q_op.last   = i_eot;
        o_q_op.length = r_count + LEN_W'(v_n);
        if (i_eot) begin
            v_b[v_n] = CH_NUL;
            v_n      = v_n + 2'd1;
            n_count  = '0;
        end else begin
            v_room = ({1'b0, r_count} + (LEN_W+1)'(v_n) + ROOM_MARGIN) <= {1'b0, i_target};
            if (v_step && v_room) begin
                if (i_byte == CH_LF) begin
                    n_pend = PEND_LF;
                end else if (i_byte == CH_CR) begin
                    v_b[v_n]        = CH_CR;
                    v_b[v_n + 2'd1] = CH_LF;
                    v_n             = v_n + 2'd2;
                end else if (i_byte == CH_CARET) begin
                    n_pend = PEND_CARET;
                end else begin
                    v_b[v_n] = i_byte;
                    v_n      = v_n + 2'd1;
                end
            end
            n_count = r_count + LEN_W'(v_n);
        end
        o_q_op.cnt   = v_n;
        o_q_op.bytes = v_b[MAX_RES-1:0];
        o_q_valid    = accept && (v_n != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= PEND_NONE;
            r_count <= '0;
        end else if (accept) begin
            r_pend  <= n_pend;
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_eot |=> r_count == '0 && r_pend == PEND_NONE)
        else $error("string state not cleared after end marker");
    a_eot_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_eot |-> o_q_valid)
        else $error("end marker produced no terminator request");
`endif

endmodule
`default_nettype wire

// ----- sv/ctc_queue.sv -----
// two-entry queue of byte groups between front and back
`default_nettype none
module ctc_queue import ctc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_not_full,
    output logic      o_valid,
    output t_op       o_op,
    input  wire logic i_pop
);

    localparam int unsigned PTR_W = $clog2(Q_DEPTH);

    t_op              r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_not_full = r_cnt < (PTR_W+1)'(Q_DEPTH);
    assign o_valid    = r_cnt != '0;
    assign o_op       = r_mem[r_rp];
    assign do_push    = i_push && o_not_full;
    assign do_pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W+1)'(Q_DEPTH))
        else $error("queue count beyond depth");
    a_push_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !o_not_full))
        else $error("request pushed into full queue");
`endif

endmodule
`default_nettype wire

// ----- sv/ctc_back.sv -----
// back end: sends the bytes of each queued group one per cycle while the result sink is ready
`default_nettype none
module ctc_back import ctc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  wire t_op  i_q_op,
    output logic      o_q_pop,
    ctc_out_if.source o_res
);

    logic       r_busy, n_busy;
    t_op        r_op,   n_op;
    logic [1:0] r_idx,  n_idx;
    logic       at_end;
    logic       take;

    assign at_end  = r_idx == (r_op.cnt - 2'd1);
    assign take    = o_res.valid && o_res.ready;
    assign o_q_pop = i_q_valid && (!r_busy || (take && at_end));

    always_comb begin
        case (r_idx)
            2'd0:    o_res.out_byte = r_op.bytes[0];
            2'd1:    o_res.out_byte = r_op.bytes[1];
            default: o_res.out_byte = r_op.bytes[2];
        endcase
        o_res.valid      = r_busy;
        o_res.is_last    = r_op.last && at_end;
        o_res.out_length = (r_op.last && at_end) ? r_op.length : '0;

        n_busy = r_busy;
        n_op   = r_op;
        n_idx  = r_idx;
        if (take && !at_end) begin
            n_idx = r_idx + 2'd1;
        end else if (!r_busy || take) begin
            n_busy = i_q_valid;
            n_op   = i_q_op;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
        end
        r_op <= n_op;
    end

`ifndef NO_ASSERTIONS
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_idx < r_op.cnt)
        else $error("byte index past end of group");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !o_res.ready |=> r_busy && $stable(r_idx))
        else $error("pending result moved while stalled");
`endif

endmodule
`default_nettype wire

// ----- sv/console_text_cleaner.sv -----
// top level of the console text cleaner: front end, request queue, back end
// an accepted item is written into a queue entry, then loaded into the back-end group register that drives results
// throughput: one result per cycle from the back end while the result sink is ready;
// an item is accepted every cycle while the two-entry queue has room, so rate is set
// by results per item (0 to 3, about 1 on plain text, up to 3 with line-break expansion)
// reset (synchronous, active low): queue and back end empty, no lookahead,
// count 0, target_size 32768
`default_nettype none
module console_text_cleaner import ctc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [LEN_W-1:0] i_cfg_data,
    ctc_in_if.sink                i_src,
    ctc_out_if.source             o_res
);

    logic [LEN_W-1:0] r_target;
    logic             f_valid;
    t_op              f_op;
    logic             q_not_full;
    logic             q_valid;
    t_op              q_op;
    logic             q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_data;
        end
    end

    ctc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_src.valid),
        .o_ready   (i_src.ready),
        .i_byte    (i_src.in_byte),
        .i_eot     (i_src.end_of_text),
        .i_target  (r_target),
        .i_q_ready (q_not_full),
        .o_q_valid (f_valid),
        .o_q_op    (f_op)
    );

    ctc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (f_valid),
        .i_op       (f_op),
        .o_not_full (q_not_full),
        .o_valid    (q_valid),
        .o_op       (q_op),
        .i_pop      (q_pop)
    );

    ctc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_op    (q_op),
        .o_q_pop   (q_pop),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire
